// ----- rtl/arte_pkg.sv -----
// Types, constants and helpers for the audio router table editor.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package arte_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W     = 32;
    localparam int CFG_W       = 6;
    localparam int MIDX_W      = 5;

    localparam logic [CFG_W-1:0] CFG_MAX_RESET = 6'd32;
    localparam logic [CFG_W-1:0] CFG_RSV_RESET = 6'd0;

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_APPEND  = 2'd1,
        REQ_SET_SRC = 2'd2,
        REQ_ENCODE  = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_AMBIG    = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_RESERVED = 3'd4
    } t_status;

    typedef enum logic {
        CFG_MAX_ENTRIES  = 1'b0,
        CFG_RSV_ENTRIES  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_req_type   req_type;
        logic [3:0]  dest_block;
        logic [3:0]  dest_channel;
        logic [3:0]  src_block;
        logic [3:0]  src_channel;
        logic [15:0] peak_level;
    } t_req;

    typedef struct packed {
        logic [31:0]       wire_word;
        t_status           status;
        logic [MIDX_W-1:0] match_index;
        logic              last;
    } t_res;

    typedef enum logic [1:0] {
        OUT_NONE   = 2'd0,
        OUT_SINGLE = 2'd1,
        OUT_COUNT  = 2'd2,
        OUT_ENTRY  = 2'd3
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     issue;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_req_type req_type;
        logic      enc_over;
        logic      scan_done;
        logic      enc_last;
        logic      cnt_zero;
    } t_dp_sts;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DISPATCH = 3'd1,
        S_SCAN     = 3'd2,
        S_FINISH   = 3'd3,
        S_ENC      = 3'd4
    } t_state;

    function automatic logic [MIDX_W-1:0] to_match_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+MIDX_W-1:0] w;
        w = {{MIDX_W{1'b0}}, idx};
        return w[MIDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/arte_ctrl.sv -----
// Sequencing state machine for the table editor.
// Depends on arte_pkg; drives arte_dp through t_dp_cmd, reads t_dp_sts.
`default_nettype none

module arte_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire arte_pkg::t_dp_sts i_sts,
    output arte_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy
);
    import arte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_sts.req_type)
                    REQ_CLEAR, REQ_APPEND: n_state = S_IDLE;
                    REQ_SET_SRC:           n_state = S_SCAN;
                    REQ_ENCODE: begin
                        if (i_sts.enc_over || i_sts.cnt_zero) n_state = S_IDLE;
                        else                                  n_state = S_ENC;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_FINISH;
            end
            S_FINISH: n_state = S_IDLE;
            S_ENC: begin
                if (i_sts.enc_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = OUT_NONE;
        o_busy        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_DISPATCH: begin
                unique case (i_sts.req_type)
                    REQ_CLEAR, REQ_APPEND: o_cmd.out_sel = OUT_SINGLE;
                    REQ_SET_SRC:           o_cmd.issue   = 1'b1;
                    REQ_ENCODE: begin
                        if (i_sts.enc_over) begin
                            o_cmd.out_sel = OUT_SINGLE;
                        end else begin
                            o_cmd.out_sel = OUT_COUNT;
                            o_cmd.issue   = 1'b1;
                        end
                    end
                endcase
            end
            S_SCAN:   o_cmd.issue = 1'b1;
            S_FINISH: o_cmd.out_sel = OUT_SINGLE;
            S_ENC: begin
                o_cmd.out_sel = OUT_ENTRY;
                o_cmd.issue   = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/arte_dp.sv -----
// Datapath: entry memory, count and config registers, scan and result logic.
// Depends on arte_pkg; commanded by arte_ctrl.
`default_nettype none

module arte_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire arte_pkg::t_req               i_req,
    input  wire arte_pkg::t_dp_cmd            i_cmd,
    output arte_pkg::t_dp_sts                 o_sts,
    input  wire logic                         i_cfg_we,
    input  wire arte_pkg::t_cfg_idx           i_cfg_index,
    input  wire logic [arte_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                              o_res_valid,
    output arte_pkg::t_res                    o_res
);
    import arte_pkg::*;

    logic [ENTRY_W-1:0] r_mem [MAX_ENTRIES];

    t_req               r_req;
    logic [CNT_W-1:0]   r_count;
    logic [CFG_W-1:0]   r_max;
    logic [CFG_W-1:0]   r_rsv;
    logic [CNT_W-1:0]   r_ptr;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [1:0]         r_hits;
    logic [IDX_W-1:0]   r_match_idx;
    logic [ENTRY_W-1:0] r_match_word;
    t_res               r_res;
    logic               r_res_valid;

    t_res               n_res;
    logic [CNT_W-1:0]   n_count;
    logic               rd_en;
    logic               hit;
    logic               full;
    logic               enc_last;
    logic [7:0]         dest;
    logic [7:0]         src;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    t_status            sgl_status;
    logic [MIDX_W-1:0]  sgl_index;

    assign dest     = {r_req.dest_block, r_req.dest_channel};
    assign src      = {r_req.src_block, r_req.src_channel};
    assign rd_en    = i_cmd.issue && (r_ptr < r_count);
    assign hit      = r_rd_vld && (r_rd_data[7:0] == dest);
    assign full     = (r_count == CNT_W'(MAX_ENTRIES));
    assign enc_last = r_rd_vld && ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count);

    assign o_sts.req_type  = r_req.req_type;
    assign o_sts.enc_over  = (7'(r_count) > 7'(r_max));
    assign o_sts.scan_done = !(r_ptr < r_count);
    assign o_sts.enc_last  = enc_last;
    assign o_sts.cnt_zero  = (r_count == '0);

    // single-result requests: status and table update
    always_comb begin
        sgl_status = ST_OK;
        sgl_index  = '0;
        wr_en      = 1'b0;
        wr_addr    = r_count[IDX_W-1:0];
        wr_data    = {r_req.peak_level, src, dest};
        n_count    = r_count;
        if (i_cmd.out_sel == OUT_SINGLE) begin
            unique case (r_req.req_type)
                REQ_CLEAR: n_count = '0;
                REQ_APPEND: begin
                    if (full) begin
                        sgl_status = ST_RANGE;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                REQ_SET_SRC: begin
                    priority if (r_hits == 2'd0) begin
                        sgl_status = ST_ABSENT;
                    end else if (r_hits > 2'd1) begin
                        sgl_status = ST_AMBIG;
                    end else if (7'(r_match_idx) < 7'(r_rsv)) begin
                        sgl_status = ST_RESERVED;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = r_match_idx;
                        wr_data   = {r_match_word[31:16], src, r_match_word[7:0]};
                        sgl_index = to_match_index(r_match_idx);
                    end
                end
                REQ_ENCODE: sgl_status = ST_RANGE;
            endcase
        end
    end

    always_comb begin
        n_res = '0;
        n_res.status = ST_OK;
        unique case (i_cmd.out_sel)
            OUT_NONE: n_res.last = 1'b0;
            OUT_SINGLE: begin
                n_res.status      = sgl_status;
                n_res.match_index = sgl_index;
                n_res.last        = 1'b1;
            end
            OUT_COUNT: begin
                n_res.wire_word = 32'(r_count);
                n_res.last      = (r_count == '0);
            end
            OUT_ENTRY: begin
                n_res.wire_word = r_rd_data;
                n_res.last      = enc_last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_max       <= CFG_MAX_RESET;
            r_rsv       <= CFG_RSV_RESET;
            r_ptr       <= '0;
            r_rd_vld    <= 1'b0;
            r_hits      <= 2'd0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_vld    <= rd_en;
            r_res_valid <= (i_cmd.out_sel != OUT_NONE);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_ENTRIES: r_max <= i_cfg_data;
                    CFG_RSV_ENTRIES: r_rsv <= i_cfg_data;
                endcase
            end
            if (i_cmd.load) begin
                r_ptr  <= '0;
                r_hits <= 2'd0;
            end else begin
                if (rd_en) r_ptr <= r_ptr + CNT_W'(1);
                if (hit && r_hits != 2'd2) r_hits <= r_hits + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (rd_en) begin
            r_rd_idx <= r_ptr[IDX_W-1:0];
        end
        if (hit && r_hits == 2'd0) begin
            r_match_idx  <= r_rd_idx;
            r_match_word <= r_rd_data;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ----- rtl/audio_router_table_editor.sv -----
// Top level of the audio routing table editor: controller plus datapath.
// Depends on arte_pkg, arte_ctrl, arte_dp.
//
//  channel  | handshake                    | payload
//  request  | i_start, o_busy              | i_req (arte_pkg::t_req)
//  result   | o_res_valid (strobe)         | o_res (arte_pkg::t_res)
//  config   | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// An item is taken when i_start is high and o_busy is low. Clear and append
// finish after dispatch; encode over the limit or on an empty table does not
// walk the entries. The set source scan and the encode walk read one entry
// per cycle from the single read port of the entry memory. Results appear in
// the cycle after they are produced and encode streams one word per cycle.
// Reset (i_rst_n, sync, low) empties the table and restores the config
// registers; no clearing pass.
// The receiver cannot stall; config is always ready.
`default_nettype none

module audio_router_table_editor (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire arte_pkg::t_req             i_req,
    output logic                            o_res_valid,
    output arte_pkg::t_res                  o_res,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire arte_pkg::t_cfg_idx         i_cfg_index,
    input  wire logic [arte_pkg::CFG_W-1:0] i_cfg_data
);
    import arte_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    arte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (o_busy)
    );

    arte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ----- rtl/arte_checker.sv -----
// Port-level checks for audio_router_table_editor, bound to the top level.
// Depends on arte_pkg.
`default_nettype none

module arte_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_start,
    input wire logic                       o_busy,
    input wire logic                       o_res_valid,
    input wire arte_pkg::t_res             o_res
);
    import arte_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after an item was taken");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK) |-> o_res.last)
        else $error("error result not marked last");

    a_stream_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |=> o_res_valid)
        else $error("encode stream broken");

    a_open_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> (o_busy && o_res.match_index == '0))
        else $error("stream word while idle or with an index");

endmodule

bind audio_router_table_editor arte_checker u_arte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

`default_nettype wire
